[hw/rtl/cfab_pkg.sv]
// Shared types, constants and frame byte layout for the CAN log API frame builder.
package cfab_pkg;

   localparam int unsigned CFAB_QUEUE_DEPTH = 2;
   localparam int unsigned FRAME_BYTES      = 38;
   localparam int unsigned POS_W            = 6;
   localparam int unsigned CSR_IDX_W        = 2;
   localparam int unsigned CSR_DATA_W       = 32;

   localparam logic [POS_W-1:0] POS_SUM_FIRST = POS_W'(3);
   localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);

   localparam logic [7:0] START_DELIM   = 8'h7E;
   localparam logic [7:0] API_LEN_HI    = 8'h00;
   localparam logic [7:0] API_LEN_LO    = 8'h22;
   localparam logic [7:0] FRAME_TYPE_TX = 8'h20;
   localparam logic [7:0] FRAME_ID      = 8'h01;
   localparam logic [7:0] UDP_PROTOCOL  = 8'h00;
   localparam logic [7:0] TX_OPTIONS    = 8'h00;
   localparam logic [7:0] CMD_CAN_LOG   = 8'h0D;

   localparam logic [CSR_IDX_W-1:0] CSR_DEST_IP         = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_UDP_PORT   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_UDP_PORT = CSR_IDX_W'(2);

   localparam logic [31:0] DEST_IP_RESET   = 32'hFFFF_FFFF;
   localparam logic [15:0] UDP_PORT_RESET  = 16'd9750;

   typedef struct packed {
      logic [31:0] seq_number;
      logic [31:0] time_tenths_ms;
      logic [31:0] can_ident;
      logic [3:0]  length_code;
      logic [63:0] payload_bytes;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [31:0] dest_ip;
      logic [15:0] dest_udp_port;
      logic [15:0] source_udp_port;
   } cfg_type;

   typedef struct packed {
      logic [31:0] seq_number;
      logic [31:0] time_tenths_ms;
      logic [31:0] can_ident;
      logic [3:0]  length_code;
      logic [63:0] data_masked;
   } msg_type;

   function automatic logic [7:0] frame_byte_at(msg_type m, cfg_type c, logic [POS_W-1:0] pos);
      logic [7:0] b;
      b = 8'h00;
      case (pos)
         6'd0:  b = START_DELIM;
         6'd1:  b = API_LEN_HI;
         6'd2:  b = API_LEN_LO;
         6'd3:  b = FRAME_TYPE_TX;
         6'd4:  b = FRAME_ID;
         6'd5:  b = c.dest_ip[31:24];
         6'd6:  b = c.dest_ip[23:16];
         6'd7:  b = c.dest_ip[15:8];
         6'd8:  b = c.dest_ip[7:0];
         6'd9:  b = c.dest_udp_port[15:8];
         6'd10: b = c.dest_udp_port[7:0];
         6'd11: b = c.source_udp_port[15:8];
         6'd12: b = c.source_udp_port[7:0];
         6'd13: b = UDP_PROTOCOL;
         6'd14: b = TX_OPTIONS;
         6'd15: b = CMD_CAN_LOG;
         6'd16: b = m.seq_number[31:24];
         6'd17: b = m.seq_number[23:16];
         6'd18: b = m.seq_number[15:8];
         6'd19: b = m.seq_number[7:0];
         6'd20: b = m.time_tenths_ms[31:24];
         6'd21: b = m.time_tenths_ms[23:16];
         6'd22: b = m.time_tenths_ms[15:8];
         6'd23: b = m.time_tenths_ms[7:0];
         6'd24: b = m.can_ident[31:24];
         6'd25: b = m.can_ident[23:16];
         6'd26: b = m.can_ident[15:8];
         6'd27: b = m.can_ident[7:0];
         6'd28: b = {4'h0, m.length_code};
         6'd29: b = m.data_masked[7:0];
         6'd30: b = m.data_masked[15:8];
         6'd31: b = m.data_masked[23:16];
         6'd32: b = m.data_masked[31:24];
         6'd33: b = m.data_masked[39:32];
         6'd34: b = m.data_masked[47:40];
         6'd35: b = m.data_masked[55:48];
         6'd36: b = m.data_masked[63:56];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[hw/rtl/cfab_front.sv]
// Front end: accepts a logged message and masks data bytes past its length code.
module cfab_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  cfab_pkg::req_type req_payload,
   input  logic             q_full,
   output logic             q_push,
   output cfab_pkg::msg_type q_msg
);
   import cfab_pkg::*;

   logic [63:0] data_masked;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         data_masked[8*k +: 8] = (req_payload.length_code > 4'(k)) ?
                                 req_payload.payload_bytes[8*k +: 8] : 8'h00;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign q_msg.seq_number     = req_payload.seq_number;
   assign q_msg.time_tenths_ms = req_payload.time_tenths_ms;
   assign q_msg.can_ident      = req_payload.can_ident;
   assign q_msg.length_code    = req_payload.length_code;
   assign q_msg.data_masked    = data_masked;

endmodule

[hw/rtl/cfab_queue.sv]
// Short message queue between the front end and the frame serialiser.
module cfab_queue #(
   parameter int unsigned DEPTH = cfab_pkg::CFAB_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cfab_pkg::msg_type push_msg,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output cfab_pkg::msg_type head_msg
);
   import cfab_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   msg_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_msg   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_msg;
      end
   end

endmodule

[hw/rtl/cfab_back.sv]
// Back end: serialises one queued message into a 38-byte API frame with checksum.
module cfab_back (
   input  logic              clock,
   input  logic              reset,
   input  cfab_pkg::cfg_type cfg,
   input  logic              head_valid,
   input  cfab_pkg::msg_type head_msg,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfab_pkg::rsp_type rsp_payload
);
   import cfab_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic             valid_ff, valid_in;
   rsp_type          data_ff, data_in;
   logic             load;
   logic             last;
   logic [7:0]       cur_byte;

   assign load     = head_valid && (!valid_ff || !rsp_stall);
   assign last     = (pos_ff == POS_LAST);
   assign cur_byte = last ? ~sum_ff : frame_byte_at(head_msg, cfg, pos_ff);
   assign pop      = load && last;

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in             = 1'b1;
         data_in.frame_byte   = cur_byte;
         data_in.end_of_frame = last;
         pos_in               = last ? '0 : pos_ff + POS_W'(1);
         sum_in               = (pos_ff < POS_SUM_FIRST) ? 8'h00 : sum_ff + cur_byte;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

[hw/rtl/can_log_api_frame_builder.sv]
// Top level of the CAN log message to UDP-transmit API frame builder.
//
//   channel  direction  handshake             carries
//   req      in         req_valid/req_stall   one logged CAN message (req_type)
//   rsp      out        rsp_valid/rsp_stall   one frame byte and end flag (rsp_type)
//   csr      in         csr_valid/csr_ready   register index and write data
//
// Each message gives 38 frame bytes, one per cycle while rsp is not stalled; the
// serialiser's byte counter steps through them in order.
// Messages queue ahead of the serialiser, so the next is taken while a frame goes out.
// First byte appears after the message is written into the queue and that byte into the output register.
// A stall on rsp holds the output register; req stalls only once the queue is full.
// Reset clears the queue, the byte counter and the output valid; registers return
// to their reset values.
module can_log_api_frame_builder #(
   parameter int unsigned QUEUE_DEPTH = cfab_pkg::CFAB_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cfab_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cfab_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cfab_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cfab_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cfab_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    head_valid;
   msg_type push_msg;
   msg_type head_msg;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEST_IP:         cfg_in.dest_ip         = csr_wdata;
            CSR_DEST_UDP_PORT:   cfg_in.dest_udp_port   = csr_wdata[15:0];
            CSR_SOURCE_UDP_PORT: cfg_in.source_udp_port = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_ip         <= DEST_IP_RESET;
         cfg_ff.dest_udp_port   <= UDP_PORT_RESET;
         cfg_ff.source_udp_port <= UDP_PORT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfab_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_msg       (push_msg)
   );

   cfab_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_msg   (push_msg),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_msg   (head_msg)
   );

   cfab_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (head_valid),
      .head_msg    (head_msg),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/cfab_checker.sv]
// Port-level checker for the frame builder, bound to its top level.
module cfab_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cfab_pkg::rsp_type rsp_payload
);
   import cfab_pkg::*;

   logic [POS_W-1:0] idx_ff, idx_in;
   logic [7:0]       pend_ff, pend_in;
   logic             req_acc;
   logic             rsp_acc;
   logic             frame_done;

   assign req_acc    = req_valid && !req_stall;
   assign rsp_acc    = rsp_valid && !rsp_stall;
   assign frame_done = rsp_acc && rsp_payload.end_of_frame;

   always_comb begin
      idx_in  = idx_ff;
      pend_in = pend_ff;
      if (rsp_acc) begin
         idx_in = rsp_payload.end_of_frame ? '0 : idx_ff + POS_W'(1);
      end
      case ({req_acc, frame_done})
         2'b10:   pend_in = pend_ff + 8'd1;
         2'b01:   pend_in = pend_ff - 8'd1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pend_ff <= '0;
      end else begin
         idx_ff  <= idx_in;
         pend_ff <= pend_in;
      end
   end

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (rsp_payload.end_of_frame == (idx_ff == POS_LAST)))
      else $error("end of frame flag not on byte 37");

   a_start_delim: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && (idx_ff == '0) |-> (rsp_payload.frame_byte == START_DELIM))
      else $error("frame does not open with start delimiter");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 8'd0))
      else $error("result shown with no message outstanding");

endmodule

bind can_log_api_frame_builder cfab_checker u_cfab_checker (.*);
